### hw/rtl/r2fft_pkg.sv
// Shared types, constants and twiddle arithmetic for the radix-2 FFT.
`default_nettype none
package r2fft_pkg;

    localparam int P_POINTS_LOG2 = 6;
    localparam int DW = 23;
    localparam int TWW = 19;
    localparam longint PI_Q30 = 64'd3373259426;
    localparam longint ONE_Q30 = 64'd1073741824;
    localparam int RSQRT2_Q17 = 92682;
    localparam logic signed [47:0] OUT_MAX = 48'sd4194303;
    localparam logic signed [47:0] OUT_MIN = -48'sd4194304;

    localparam logic [1:0] CFG_SIZE = 2'd0;
    localparam logic [1:0] CFG_INV  = 2'd1;
    localparam logic [1:0] CFG_BAL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_PERM, S_BF_ADR, S_BF_RD, S_BF_MUL, S_BF_WRA, S_BF_WRB,
        S_OUT_RD, S_OUT_MUL, S_OUT_FIN, S_OUT_HOLD
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic wr_a;
        logic wr_b;
        logic swap;
        logic out_mul;
        logic out_fin;
        logic last;
    } t_cmd;

    function automatic logic signed [DW-1:0] sat23(input logic signed [47:0] v);
        logic signed [DW-1:0] r;
        if (v > OUT_MAX) r = DW'(OUT_MAX);
        else if (v < OUT_MIN) r = DW'(OUT_MIN);
        else r = v[DW-1:0];
        return r;
    endfunction

    function automatic longint q30_to_q17(input longint v);
        longint r;
        r = (v < 0) ? 64'sd0 : v;
        r = (r + 4096) >>> 13;
        if (r > 131072) r = 131072;
        return r;
    endfunction

    // shift-and-subtract quotient, used only to build the constant twiddle table
    function automatic longint unsigned udiv_c(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q, rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // cos and sin of pi*num/2^den in Q1.17, packed {cos, sin}
    function automatic logic [2*TWW-1:0] tw_calc(input int unsigned num,
                                                 input int unsigned den);
        longint unsigned full, k, x, x2, tc, ts;
        longint cs, sn, cq, sq;
        logic mir;
        logic [TWW-1:0] c, s;
        full = 64'd1 << den;
        mir = (2 * longint'(num)) > full;
        k = mir ? full - num : num;
        x = (den == 0) ? PI_Q30 * k : (PI_Q30 * k + (64'd1 << (den - 1))) >> den;
        x2 = (x * x) >> 30;
        tc = ONE_Q30;
        ts = x;
        cs = ONE_Q30;
        sn = x;
        for (int i = 1; i <= 9; i++) begin
            tc = udiv_c((tc * x2) >> 30, longint'((2 * i - 1) * (2 * i)));
            ts = udiv_c((ts * x2) >> 30, longint'((2 * i) * (2 * i + 1)));
            if ((i & 1) != 0) begin
                cs = cs - longint'(tc);
                sn = sn - longint'(ts);
            end else begin
                cs = cs + longint'(tc);
                sn = sn + longint'(ts);
            end
        end
        cq = q30_to_q17(cs);
        sq = q30_to_q17(sn);
        c = mir ? TWW'(-cq) : TWW'(cq);
        s = TWW'(sq);
        return {c, s};
    endfunction

endpackage
`default_nettype wire

### hw/rtl/r2fft_dp.sv
// Datapath: work store, twiddle table, butterfly and output scaling.
`default_nettype none
module r2fft_dp #(
    parameter int POINTS_LOG2 = r2fft_pkg::P_POINTS_LOG2,
    parameter int LW = $clog2(POINTS_LOG2 + 1),
    parameter int TIW = (POINTS_LOG2 > 1) ? POINTS_LOG2 - 1 : 1
) (
    input  wire                           i_clk,
    input  wire r2fft_pkg::t_cmd          i_cmd,
    input  wire [POINTS_LOG2-1:0]         i_addr_a,
    input  wire [POINTS_LOG2-1:0]         i_addr_b,
    input  wire [TIW-1:0]                 i_tw_idx,
    input  wire [LW-1:0]                  i_l,
    input  wire                           i_inv,
    input  wire                           i_bal,
    input  wire signed [15:0]             i_sample_real,
    input  wire signed [15:0]             i_sample_imag,
    output logic signed [22:0]            o_bin_real,
    output logic signed [22:0]            o_bin_imag,
    output logic [5:0]                    o_bin_index,
    output logic                          o_last_bin
);
    localparam int DEPTH = 1 << POINTS_LOG2;
    localparam int TWN = 1 << (POINTS_LOG2 - 1);
    localparam int DW = r2fft_pkg::DW;
    localparam int TWW = r2fft_pkg::TWW;

    logic [2*DW-1:0] r_mem [DEPTH];
    logic [2*DW-1:0] r_rd_a, r_rd_b, r_hold;
    logic [2*TWW-1:0] tw_rom [TWN];
    logic [2*TWW-1:0] r_tw;
    logic signed [41:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [DW-1:0] r_ar, r_ai;
    logic signed [40:0] r_om_re, r_om_im;

    for (genvar g = 0; g < TWN; g++) begin : g_tw
        assign tw_rom[g] = r2fft_pkg::tw_calc(g, POINTS_LOG2 - 1);
    end

    logic signed [DW-1:0] ar, ai, br, bi;
    logic signed [TWW-1:0] wr, ws, wi;
    logic signed [42:0] tr_sum, ti_sum;
    logic signed [25:0] tr, ti;
    logic [2*DW-1:0] a_new, b_new, wdata;
    logic [POINTS_LOG2-1:0] waddr;
    logic we;
    logic signed [17:0] fac;
    logic [4:0] sh;
    logic signed [41:0] rnd, sre, sim;

    assign ar = r_rd_a[2*DW-1:DW];
    assign ai = r_rd_a[DW-1:0];
    assign br = r_rd_b[2*DW-1:DW];
    assign bi = r_rd_b[DW-1:0];
    assign wr = r_tw[2*TWW-1:TWW];
    assign ws = r_tw[TWW-1:0];
    assign wi = i_inv ? ws : -ws;

    always_comb begin
        tr_sum = 43'(r_p1) - 43'(r_p2) + 43'sd65536;
        ti_sum = 43'(r_p3) + 43'(r_p4) + 43'sd65536;
        tr = tr_sum[42:17];
        ti = ti_sum[42:17];
        a_new = {r2fft_pkg::sat23(48'(r_ar) + 48'(tr)), r2fft_pkg::sat23(48'(r_ai) + 48'(ti))};
        b_new = {r2fft_pkg::sat23(48'(r_ar) - 48'(tr)), r2fft_pkg::sat23(48'(r_ai) - 48'(ti))};
        we = 1'b0;
        waddr = i_addr_a;
        wdata = i_cmd.swap ? r_rd_b : a_new;
        if (i_cmd.load) begin
            we = 1'b1;
            wdata = {DW'(i_sample_real), DW'(i_sample_imag)};
        end else if (i_cmd.wr_a) begin
            we = 1'b1;
        end else if (i_cmd.wr_b) begin
            we = 1'b1;
            waddr = i_addr_b;
            wdata = r_hold;
        end
    end

    // scale factor and round shift for readout
    always_comb begin
        fac = 18'sd1;
        sh = 5'd0;
        if (i_bal) begin
            if (i_l[0]) begin
                fac = 18'(r2fft_pkg::RSQRT2_Q17);
                sh = 5'd17 + 5'(i_l >> 1);
            end else begin
                sh = 5'(i_l >> 1);
            end
        end else if (i_inv) begin
            sh = 5'(i_l);
        end
        rnd = (sh == 5'd0) ? 42'sd0 : (42'sd1 <<< (sh - 5'd1));
        sre = (42'(r_om_re) + rnd) >>> sh;
        sim = (42'(r_om_im) + rnd) >>> sh;
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd_a <= r_mem[i_addr_a];
        r_rd_b <= r_mem[i_addr_b];
        r_tw <= tw_rom[i_tw_idx];
        if (i_cmd.mul) begin
            r_p1 <= wr * br;
            r_p2 <= wi * bi;
            r_p3 <= wr * bi;
            r_p4 <= wi * br;
            r_ar <= ar;
            r_ai <= ai;
        end
        if (i_cmd.wr_a) r_hold <= i_cmd.swap ? r_rd_a : b_new;
        if (i_cmd.out_mul) begin
            r_om_re <= ar * fac;
            r_om_im <= ai * fac;
        end
        if (i_cmd.out_fin) begin
            o_bin_real <= r2fft_pkg::sat23(48'(sre));
            o_bin_imag <= r2fft_pkg::sat23(48'(sim));
            o_bin_index <= 6'((POINTS_LOG2 + 6)'(i_addr_a));
            o_last_bin <= i_cmd.last;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/r2fft_ctrl.sv
// Controller: configuration, load count and the transform/readout sequencer.
`default_nettype none
module r2fft_ctrl #(
    parameter int POINTS_LOG2 = r2fft_pkg::P_POINTS_LOG2,
    parameter int LW = $clog2(POINTS_LOG2 + 1),
    parameter int TIW = (POINTS_LOG2 > 1) ? POINTS_LOG2 - 1 : 1
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_valid,
    input  wire [1:0]                i_cfg_index,
    input  wire [2:0]                i_cfg_data,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output r2fft_pkg::t_cmd          o_cmd,
    output logic [POINTS_LOG2-1:0]   o_addr_a,
    output logic [POINTS_LOG2-1:0]   o_addr_b,
    output logic [TIW-1:0]           o_tw_idx,
    output logic [LW-1:0]            o_l,
    output logic                     o_inv,
    output logic                     o_bal
);
    localparam int P = POINTS_LOG2;

    r2fft_pkg::t_state r_state, n_state;
    logic [2:0] r_size;
    logic r_inv, r_bal;
    logic [P:0] r_count, n_count, r_cnt, n_cnt;
    logic [P-1:0] r_bf, n_bf, r_addr_a, n_addr_a, r_addr_b, n_addr_b;
    logic [LW-1:0] r_st, n_st, r_l, n_l;
    logic [TIW-1:0] r_tw, n_tw;
    logic r_swap, n_swap;

    logic [LW-1:0] l_now;
    logic [P:0] n_now, n_len, half_n;
    logic [P-1:0] idx, rv, rev, half, jj, ia;

    always_comb begin
        l_now = (32'(r_size) > P) ? LW'(P) : LW'(r_size);
        n_now = (P + 1)'(1) << l_now;
        n_len = (P + 1)'(1) << r_l;
        half_n = n_len >> 1;
        idx = r_cnt[P-1:0];
        for (int b = 0; b < P; b++) rv[P-1-b] = idx[b];
        rev = rv >> (LW'(P) - r_l);
        half = P'((P + 1)'(1) << (r_st - LW'(1)));
        jj = r_bf & (half - P'(1));
        ia = ((r_bf >> (r_st - LW'(1))) << r_st) | jj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 3'd6;
            r_inv <= 1'b0;
            r_bal <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                r2fft_pkg::CFG_SIZE: r_size <= i_cfg_data;
                r2fft_pkg::CFG_INV:  r_inv <= i_cfg_data[0];
                r2fft_pkg::CFG_BAL:  r_bal <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= r2fft_pkg::S_IDLE;
            r_count <= '0;
            r_cnt <= '0;
            r_bf <= '0;
            r_st <= '0;
            r_l <= '0;
            r_swap <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cnt <= n_cnt;
            r_bf <= n_bf;
            r_st <= n_st;
            r_l <= n_l;
            r_swap <= n_swap;
        end
        r_addr_a <= n_addr_a;
        r_addr_b <= n_addr_b;
        r_tw <= n_tw;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_cnt = r_cnt;
        n_bf = r_bf;
        n_st = r_st;
        n_l = r_l;
        n_swap = r_swap;
        n_addr_a = r_addr_a;
        n_addr_b = r_addr_b;
        n_tw = r_tw;
        o_cmd = '0;
        o_in_stall = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            r2fft_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_count = r_count + (P + 1)'(1);
                    if (n_count >= n_now) begin
                        n_count = '0;
                        n_l = l_now;
                        n_cnt = '0;
                        n_state = r2fft_pkg::S_PERM;
                    end
                end
            end
            r2fft_pkg::S_PERM: begin
                if (r_cnt == n_len) begin
                    if (r_l == '0) begin
                        n_cnt = '0;
                        n_addr_a = '0;
                        n_state = r2fft_pkg::S_OUT_RD;
                    end else begin
                        n_st = LW'(1);
                        n_bf = '0;
                        n_state = r2fft_pkg::S_BF_ADR;
                    end
                end else if (idx < rev) begin
                    n_addr_a = idx;
                    n_addr_b = rev;
                    n_swap = 1'b1;
                    n_state = r2fft_pkg::S_BF_RD;
                end else begin
                    n_cnt = r_cnt + (P + 1)'(1);
                end
            end
            r2fft_pkg::S_BF_ADR: begin
                n_addr_a = ia;
                n_addr_b = ia | half;
                n_tw = TIW'(jj << (LW'(P) - r_st));
                n_swap = 1'b0;
                n_state = r2fft_pkg::S_BF_RD;
            end
            r2fft_pkg::S_BF_RD: n_state = r2fft_pkg::S_BF_MUL;
            r2fft_pkg::S_BF_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = r2fft_pkg::S_BF_WRA;
            end
            r2fft_pkg::S_BF_WRA: begin
                o_cmd.wr_a = 1'b1;
                o_cmd.swap = r_swap;
                n_state = r2fft_pkg::S_BF_WRB;
            end
            r2fft_pkg::S_BF_WRB: begin
                o_cmd.wr_b = 1'b1;
                if (r_swap) begin
                    n_cnt = r_cnt + (P + 1)'(1);
                    n_state = r2fft_pkg::S_PERM;
                end else if ((P + 1)'(r_bf) + (P + 1)'(1) == half_n) begin
                    if (r_st == r_l) begin
                        n_cnt = '0;
                        n_addr_a = '0;
                        n_state = r2fft_pkg::S_OUT_RD;
                    end else begin
                        n_st = r_st + LW'(1);
                        n_bf = '0;
                        n_state = r2fft_pkg::S_BF_ADR;
                    end
                end else begin
                    n_bf = r_bf + P'(1);
                    n_state = r2fft_pkg::S_BF_ADR;
                end
            end
            r2fft_pkg::S_OUT_RD: n_state = r2fft_pkg::S_OUT_MUL;
            r2fft_pkg::S_OUT_MUL: begin
                o_cmd.out_mul = 1'b1;
                n_state = r2fft_pkg::S_OUT_FIN;
            end
            r2fft_pkg::S_OUT_FIN: begin
                o_cmd.out_fin = 1'b1;
                o_cmd.last = (r_cnt == n_len - (P + 1)'(1));
                n_state = r2fft_pkg::S_OUT_HOLD;
            end
            r2fft_pkg::S_OUT_HOLD: begin
                o_out_valid = 1'b1;
                // advance once the bin beat is taken
                if (!i_out_stall) begin
                    if (r_cnt + (P + 1)'(1) == n_len) begin
                        n_state = r2fft_pkg::S_IDLE;
                    end else begin
                        n_cnt = r_cnt + (P + 1)'(1);
                        n_addr_a = n_cnt[P-1:0];
                        n_state = r2fft_pkg::S_OUT_RD;
                    end
                end
            end
            default: n_state = r2fft_pkg::S_IDLE;
        endcase
    end

    assign o_addr_a = (r_state == r2fft_pkg::S_IDLE) ? r_count[P-1:0] : r_addr_a;
    assign o_addr_b = r_addr_b;
    assign o_tw_idx = r_tw;
    assign o_l = r_l;
    assign o_inv = r_inv;
    assign o_bal = r_bal;
endmodule
`default_nettype wire

### hw/rtl/radix2_fft.sv
// Top level of the radix-2 FFT: controller plus datapath.
// Samples are loaded one beat per cycle until 2^L have arrived, L being
// min(size_log2, POINTS_LOG2). The input then stalls while the block runs a
// bit-reversal pass, L stages of n/2 butterflies on the single butterfly
// unit and the one write port of the work store, then emits the n bins in
// natural order, each bin held while the output stalls. Input is taken
// again once the last bin beat is gone. Configuration writes are always
// ready.
`default_nettype none
module radix2_fft #(
    parameter int POINTS_LOG2 = r2fft_pkg::P_POINTS_LOG2
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [1:0]          i_cfg_index,
    input  wire [2:0]          i_cfg_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire signed [15:0]  i_sample_real,
    input  wire signed [15:0]  i_sample_imag,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [22:0] o_bin_real,
    output logic signed [22:0] o_bin_imag,
    output logic [5:0]         o_bin_index,
    output logic               o_last_bin
);
    localparam int LW = $clog2(POINTS_LOG2 + 1);
    localparam int TIW = (POINTS_LOG2 > 1) ? POINTS_LOG2 - 1 : 1;

    r2fft_pkg::t_cmd cmd;
    logic [POINTS_LOG2-1:0] addr_a, addr_b;
    logic [TIW-1:0] tw_idx;
    logic [LW-1:0] l;
    logic inv, bal;

    assign o_cfg_ready = 1'b1;

    r2fft_ctrl #(.POINTS_LOG2(POINTS_LOG2), .LW(LW), .TIW(TIW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_cmd(cmd), .o_addr_a(addr_a), .o_addr_b(addr_b), .o_tw_idx(tw_idx),
        .o_l(l), .o_inv(inv), .o_bal(bal)
    );

    r2fft_dp #(.POINTS_LOG2(POINTS_LOG2), .LW(LW), .TIW(TIW)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_addr_a(addr_a), .i_addr_b(addr_b),
        .i_tw_idx(tw_idx), .i_l(l), .i_inv(inv), .i_bal(bal),
        .i_sample_real(i_sample_real), .i_sample_imag(i_sample_imag),
        .o_bin_real(o_bin_real), .o_bin_imag(o_bin_imag),
        .o_bin_index(o_bin_index), .o_last_bin(o_last_bin)
    );
endmodule
`default_nettype wire
